// ----- rtl/core/spbr_pkg.sv -----
// shared constants, types and helpers for the range sorting block
package spbr_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int FIELD_BITS = 16;
  localparam int RANGE_BITS = 32;
  localparam int EXT_W      = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int SUM_W      = SQ_W + 2;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one stored point with its sort key
  typedef struct packed {
    logic [RANGE_BITS-1:0] key;
    coord_t                x;
    coord_t                y;
    coord_t                z;
  } entry_t;

  // control that travels with a point through the range pipeline
  typedef struct packed {
    logic ins;
    logic last;
  } pipe_ctl_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

  // take the low coordinate bits of a port field, zero-extended
  function automatic coord_t ext_coord(input logic [FIELD_BITS-1:0] v);
    logic [EXT_W-1:0] t;
    t = EXT_W'(v);
    return t[COORD_BITS-1:0];
  endfunction

  // bring a stored coordinate back to port width
  function automatic logic [FIELD_BITS-1:0] out_coord(input coord_t c);
    logic signed [EXT_W-1:0] t;
    t = EXT_W'(c);
    return t[FIELD_BITS-1:0];
  endfunction

endpackage

// ----- rtl/core/spbr_range.sv -----
// two-stage pipeline that computes the squared range of each point
module spbr_range import spbr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  pipe_ctl_t in_ctl,
  input  coord_t    in_x,
  input  coord_t    in_y,
  input  coord_t    in_z,
  output pipe_ctl_t out_ctl,
  output entry_t    out_ent
);

  function automatic logic [SQ_W-1:0] square(input coord_t c);
    logic signed [SQ_W-1:0] w;
    w = SQ_W'(c);
    return unsigned'(w * w);
  endfunction

  pipe_ctl_t        ctl1;
  coord_t           x1, y1, z1;
  logic [SQ_W-1:0]  sq_x, sq_y, sq_z;
  logic [SUM_W-1:0] sum;
  logic [RANGE_BITS-1:0] range_sat;

  // stage one: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= in_ctl;
    end
    x1   <= in_x;
    y1   <= in_y;
    z1   <= in_z;
    sq_x <= square(in_x);
    sq_y <= square(in_y);
    sq_z <= square(in_z);
  end

  // sum with saturation when the sum outgrows the key
  always_comb begin
    sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
    if (SUM_W > RANGE_BITS && (sum >> RANGE_BITS) != '0) begin
      range_sat = '1;
    end else begin
      range_sat = RANGE_BITS'(sum);
    end
  end

  // stage two: finished entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= ctl1;
    end
    out_ent.key <= range_sat;
    out_ent.x   <= x1;
    out_ent.y   <= y1;
    out_ent.z   <= z1;
  end

endmodule

// ----- rtl/core/spbr_cell.sv -----
// one cell of the sorting chain: holds an entry, inserts or shifts
module spbr_cell import spbr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    new_ent,
  input  logic      left_take,
  input  logic      left_valid,
  input  entry_t    left_ent,
  input  logic      right_valid,
  input  entry_t    right_ent,
  output logic      take,
  output logic      valid,
  output entry_t    ent
);

  // strict compare keeps equal keys in arrival order
  assign take = !valid || (new_ent.key < ent.key);

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= right_valid;
    end else if (ctl.ins && take) begin
      valid <= left_take ? left_valid : 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      ent <= right_ent;
    end else if (ctl.ins && take) begin
      ent <= left_take ? left_ent : new_ent;
    end
  end

endmodule

// ----- rtl/core/sort_points_by_range_top.sv -----
// Sorts a point cloud by squared range from the origin. Points enter one per cycle until the
// point flagged last; each point passes through the squaring pipeline and is then placed
// into a chain of MAX_POINTS cells kept in ascending order (ties stay in arrival order). Once
// the last point has left the squaring pipeline, the chain drains from its head, one result
// per cycle while the output is not stalled. The input is stalled from the last point of a
// run until its final result is taken. Points beyond MAX_POINTS are dropped and set the
// overflow flag on every result of that run.
module sort_points_by_range_top import spbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FIELD_BITS-1:0] coord_x,
  input  logic [FIELD_BITS-1:0] coord_y,
  input  logic [FIELD_BITS-1:0] coord_z,
  input  logic                  last_point,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FIELD_BITS-1:0] out_x,
  output logic [FIELD_BITS-1:0] out_y,
  output logic [FIELD_BITS-1:0] out_z,
  output logic [RANGE_BITS-1:0] range_sq,
  output logic                  overflow,
  output logic                  end_of_run
);

  logic             in_fire;
  logic             full;
  logic [CNT_W-1:0] count;
  logic             dropped;
  logic             closing;
  logic             draining;
  logic             out_fire;
  logic             drain_done;
  pipe_ctl_t        in_ctl;
  pipe_ctl_t        ins_ctl;
  entry_t           ins_ent;
  cell_ctl_t        cell_ctl;

  logic   [MAX_POINTS-1:0] take;
  logic   [MAX_POINTS-1:0] cell_valid;
  entry_t [MAX_POINTS-1:0] cell_ent;

  // input transaction and capacity
  assign in_stall   = closing;
  assign in_fire    = in_valid && !in_stall;
  assign full       = (count == CNT_W'(MAX_POINTS));
  assign in_ctl.ins  = in_fire && !full;
  assign in_ctl.last = in_fire && last_point;

  // output transaction
  assign out_valid  = draining && cell_valid[0];
  assign out_fire   = out_valid && !out_stall;
  assign end_of_run = !cell_valid[1];
  assign drain_done = out_fire && end_of_run;

  // run bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dropped  <= 1'b0;
      closing  <= 1'b0;
      draining <= 1'b0;
    end else begin
      if (in_fire) begin
        if (last_point) begin
          count <= '0;
        end else if (!full) begin
          count <= count + 1'b1;
        end
      end
      if (in_fire && full) begin
        dropped <= 1'b1;
      end else if (drain_done) begin
        dropped <= 1'b0;
      end
      if (in_ctl.last) begin
        closing <= 1'b1;
      end else if (drain_done) begin
        closing <= 1'b0;
      end
      if (ins_ctl.last) begin
        draining <= 1'b1;
      end else if (drain_done) begin
        draining <= 1'b0;
      end
    end
  end

  // squared range pipeline
  spbr_range u_range (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (in_ctl),
    .in_x    (ext_coord(coord_x)),
    .in_y    (ext_coord(coord_y)),
    .in_z    (ext_coord(coord_z)),
    .out_ctl (ins_ctl),
    .out_ent (ins_ent)
  );

  assign cell_ctl.ins   = ins_ctl.ins;
  assign cell_ctl.shift = out_fire;

  // sorting chain
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic   lt, lv, rv;
    entry_t le, re;
    if (i == 0) begin : g_head
      assign lt = 1'b0;
      assign lv = 1'b0;
      assign le = cell_ent[i];
    end else begin : g_mid
      assign lt = take[i-1];
      assign lv = cell_valid[i-1];
      assign le = cell_ent[i-1];
    end
    if (i == MAX_POINTS - 1) begin : g_tail
      assign rv = 1'b0;
      assign re = cell_ent[i];
    end else begin : g_body
      assign rv = cell_valid[i+1];
      assign re = cell_ent[i+1];
    end
    spbr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (cell_ctl),
      .new_ent     (ins_ent),
      .left_take   (lt),
      .left_valid  (lv),
      .left_ent    (le),
      .right_valid (rv),
      .right_ent   (re),
      .take        (take[i]),
      .valid       (cell_valid[i]),
      .ent         (cell_ent[i])
    );
  end

  // result fields from the head cell
  assign out_x    = out_coord(cell_ent[0].x);
  assign out_y    = out_coord(cell_ent[0].y);
  assign out_z    = out_coord(cell_ent[0].z);
  assign range_sq = cell_ent[0].key;
  assign overflow = dropped;

  // no input is taken while results are leaving
  a_stall_in_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open during drain");

  // the chain is empty after the final result of a run
  a_empty_after_run: assert property (@(posedge clk) disable iff (rst)
    drain_done |=> (cell_valid == '0) && !closing)
    else $error("chain not empty after end of run");

  // occupied cells form a contiguous run from the head
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("gap in sorting chain");

  // head of the chain is in ascending order
  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (cell_valid[0] && cell_valid[1]) |-> (cell_ent[0].key <= cell_ent[1].key))
    else $error("chain out of order");

endmodule
